@@ hdl/lob_pkg.sv @@
// ============================================================================
// lob_pkg
// Shared widths, constants and helpers of the look-at camera basis datapath.
// ============================================================================
package lob_pkg;

    localparam int MW          = 30;          // scaled magnitude width
    localparam int SW          = 2 * MW + 2;  // sum of three squares
    localparam int RW          = SW / 2;      // square root width
    localparam int FB          = 16;          // fraction bits of a unit component
    localparam int QW          = FB + 1;      // quotient bits
    localparam int NW          = MW + FB + 2; // dividend width
    localparam int UW          = 18;          // unit component width, Q1.16
    localparam int TW          = 48;          // first cross product width
    localparam int OUT_TDATA_W = ((9 * UW + 7) / 8) * 8;

    localparam logic signed [UW-1:0] ONE_Q16 = 18'sd65536;

    localparam logic [1:0] VIEW_NORMAL = 2'd0;
    localparam logic [1:0] VIEW_DOWN   = 2'd1;
    localparam logic [1:0] VIEW_UP     = 2'd2;

    // Q2.32 to Q1.16, round half away from zero, clamp to one.
    function automatic logic signed [UW-1:0] rnd_q16(input logic signed [2*UW:0] x);
        logic [2*UW:0]          m;
        logic [2*UW:0]          r;
        logic signed [UW-1:0]   s;
        m = x[2*UW] ? (2*UW+1)'(-x) : (2*UW+1)'(x);
        r = (m + (2*UW+1)'(32768)) >> FB;
        if (r > (2*UW+1)'(65536)) begin
            r = (2*UW+1)'(65536);
        end
        s = signed'(UW'(r));
        return x[2*UW] ? -s : s;
    endfunction

endpackage

@@ hdl/lookat_orthonormal_basis_top.sv @@
// ============================================================================
// lookat_orthonormal_basis_top
// Look-at camera basis: w = norm(eye - target), u = norm(up x w), v = w x u.
// ============================================================================
// Usage:
//   Slave stream: one view setup per transfer (eye, target, up, Q16.16).
//   Master stream: one basis per transfer (u, v, w in Q1.16) and a
//   degenerate flag in tuser; a degenerate basis carries all zeros.
//   Eye straight above or below target gives a fixed basis.
//   Throughput: one transfer per cycle on both sides while not stalled.
//   Pipeline: front stage, up-vector scaling (4), two normalizers (each:
//   scaling, squares, sum, 31 root stages, dividend setup, 17 quotient
//   stages, output), two cross product stage pairs, output register.
//   Stall: the whole pipeline holds while the output register is full and
//   not taken; o_s_axis_tready then drops, nothing is lost or repeated.
//   Reset: synchronous, active low; clears all valid bits, pipeline empty.
// ============================================================================
module lookat_orthonormal_basis_top #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_TDATA_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [IN_TDATA_W-1:0]              i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // right_x, right_y, right_z, upward_x, upward_y, upward_z, back_x, back_y, back_z
    output logic [lob_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // degenerate
    output logic [0:0]                         o_m_axis_tuser
);
    import lob_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SB0W = 3 * DW + 2;
    localparam int SB1W = 3 * MW + 6;
    localparam int SB2W = 3 * UW + 3;
    localparam int PAW  = MW + 1 + UW;
    localparam int PBW  = 2 * UW;

    logic en;

    // front stage
    logic                          r_av;
    logic signed [DW-1:0]          r_d   [3];
    logic signed [COORD_WIDTH-1:0] r_upv [3];
    logic [1:0]                    r_spc;
    logic signed [DW-1:0]          n_d   [3];
    logic [1:0]                    n_spc;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_d[l] = DW'(signed'(i_s_axis_tdata[l*COORD_WIDTH +: COORD_WIDTH]))
                   - DW'(signed'(i_s_axis_tdata[(l+3)*COORD_WIDTH +: COORD_WIDTH]));
        end
        n_spc = VIEW_NORMAL;
        if (n_d[0] == '0 && n_d[2] == '0) begin
            if (n_d[1] > 0) begin
                n_spc = VIEW_DOWN;
            end else if (n_d[1] < 0) begin
                n_spc = VIEW_UP;
            end
        end
    end

    // up-vector scaling
    logic            sc_vld, sc_nz;
    logic [MW-1:0]   sc_mag [3];
    logic [2:0]      sc_neg;
    logic [SB0W-1:0] sc_sb;

    lob_scale #(.W(COORD_WIDTH), .SBW(SB0W)) u_upscale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_av),
        .i_c     (r_upv),
        .i_sb    ({r_spc, r_d[2], r_d[1], r_d[0]}),
        .o_vld   (sc_vld),
        .o_nz    (sc_nz),
        .o_mag   (sc_mag),
        .o_neg   (sc_neg),
        .o_sb    (sc_sb)
    );

    logic signed [DW-1:0] sc_d [3];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sc_d[l] = signed'(sc_sb[l*DW +: DW]);
        end
    end

    // w normalization
    logic                 n1_vld, n1_nz;
    logic signed [UW-1:0] n1_w [3];
    logic [SB1W-1:0]      n1_sb;

    lob_norm #(.W(DW), .SBW(SB1W)) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sc_vld),
        .i_c     (sc_d),
        .i_sb    ({sc_sb[3*DW +: 2], sc_nz, sc_neg, sc_mag[2], sc_mag[1], sc_mag[0]}),
        .o_vld   (n1_vld),
        .o_nz    (n1_nz),
        .o_u     (n1_w),
        .o_sb    (n1_sb)
    );

    // up x w
    logic signed [MW:0]    upa [3];
    logic                  r_pv, r_tv;
    logic signed [PAW-1:0] r_pa [3];
    logic signed [PAW-1:0] r_pb [3];
    logic signed [UW-1:0]  r_pw [3];
    logic                  r_pdg;
    logic [1:0]            r_pspc;
    logic signed [TW-1:0]  r_t  [3];
    logic signed [UW-1:0]  r_tw [3];
    logic                  r_tdg;
    logic [1:0]            r_tspc;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            upa[l] = n1_sb[3*MW+l] ? -signed'({1'b0, n1_sb[l*MW +: MW]})
                                   : signed'({1'b0, n1_sb[l*MW +: MW]});
        end
    end

    // u normalization
    logic                 n2_vld, n2_nz;
    logic signed [UW-1:0] n2_u [3];
    logic [SB2W-1:0]      n2_sb;

    lob_norm #(.W(TW), .SBW(SB2W)) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_tv),
        .i_c     (r_t),
        .i_sb    ({r_tspc, r_tdg, r_tw[2], r_tw[1], r_tw[0]}),
        .o_vld   (n2_vld),
        .o_nz    (n2_nz),
        .o_u     (n2_u),
        .o_sb    (n2_sb)
    );

    // w x u
    logic signed [UW-1:0]  n2_w [3];
    logic                  r_qv, r_rv;
    logic signed [PBW-1:0] r_qa [3];
    logic signed [PBW-1:0] r_qb [3];
    logic signed [UW-1:0]  r_qu [3];
    logic signed [UW-1:0]  r_qw [3];
    logic                  r_qdg;
    logic [1:0]            r_qspc;
    logic signed [UW-1:0]  r_ru [3];
    logic signed [UW-1:0]  r_rw [3];
    logic signed [UW-1:0]  r_rvv [3];
    logic                  r_rdg;
    logic [1:0]            r_rspc;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n2_w[l] = signed'(n2_sb[l*UW +: UW]);
        end
    end

    // output register
    logic                 r_ovld;
    logic signed [UW-1:0] r_ou [3];
    logic signed [UW-1:0] r_ovec [3];
    logic signed [UW-1:0] r_ow [3];
    logic                 r_odg;
    logic signed [UW-1:0] n_ou [3];
    logic signed [UW-1:0] n_ovec [3];
    logic signed [UW-1:0] n_ow [3];
    logic                 n_odg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_ou[l]   = '0;
            n_ovec[l] = '0;
            n_ow[l]   = '0;
        end
        n_odg = 1'b0;
        case (r_rspc)
            VIEW_DOWN: begin
                n_ou[2]   = ONE_Q16;
                n_ovec[0] = ONE_Q16;
                n_ow[1]   = ONE_Q16;
            end
            VIEW_UP: begin
                n_ou[0]   = ONE_Q16;
                n_ovec[2] = ONE_Q16;
                n_ow[1]   = -ONE_Q16;
            end
            default: begin
                if (r_rdg) begin
                    n_odg = 1'b1;
                end else begin
                    n_ou   = r_ru;
                    n_ovec = r_rvv;
                    n_ow   = r_rw;
                end
            end
        endcase
    end

    assign en = !r_ovld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av   <= 1'b0;
            r_pv   <= 1'b0;
            r_tv   <= 1'b0;
            r_qv   <= 1'b0;
            r_rv   <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_av   <= i_s_axis_tvalid;
            r_pv   <= n1_vld;
            r_tv   <= r_pv;
            r_qv   <= n2_vld;
            r_rv   <= r_qv;
            r_ovld <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_d[l]   <= n_d[l];
                r_upv[l] <= signed'(i_s_axis_tdata[(l+6)*COORD_WIDTH +: COORD_WIDTH]);
            end
            r_spc <= n_spc;

            r_pa[0] <= upa[1] * n1_w[2];
            r_pb[0] <= upa[2] * n1_w[1];
            r_pa[1] <= upa[2] * n1_w[0];
            r_pb[1] <= upa[0] * n1_w[2];
            r_pa[2] <= upa[0] * n1_w[1];
            r_pb[2] <= upa[1] * n1_w[0];
            r_pw    <= n1_w;
            r_pdg   <= !n1_nz || !n1_sb[3*MW+3];
            r_pspc  <= n1_sb[3*MW+4 +: 2];

            for (int l = 0; l < 3; l++) begin
                r_t[l] <= TW'(r_pa[l] - r_pb[l]);
            end
            r_tw   <= r_pw;
            r_tdg  <= r_pdg;
            r_tspc <= r_pspc;

            r_qa[0] <= n2_w[1] * n2_u[2];
            r_qb[0] <= n2_w[2] * n2_u[1];
            r_qa[1] <= n2_w[2] * n2_u[0];
            r_qb[1] <= n2_w[0] * n2_u[2];
            r_qa[2] <= n2_w[0] * n2_u[1];
            r_qb[2] <= n2_w[1] * n2_u[0];
            r_qu    <= n2_u;
            r_qw    <= n2_w;
            r_qdg   <= n2_sb[3*UW] || !n2_nz;
            r_qspc  <= n2_sb[3*UW+1 +: 2];

            for (int l = 0; l < 3; l++) begin
                r_rvv[l] <= rnd_q16((PBW+1)'(r_qa[l]) - (PBW+1)'(r_qb[l]));
            end
            r_ru   <= r_qu;
            r_rw   <= r_qw;
            r_rdg  <= r_qdg;
            r_rspc <= r_qspc;

            r_ou   <= n_ou;
            r_ovec <= n_ovec;
            r_ow   <= n_ow;
            r_odg  <= n_odg;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tuser  = r_odg;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 9 * UW)'(0),
                              r_ow[2], r_ow[1], r_ow[0],
                              r_ovec[2], r_ovec[1], r_ovec[0],
                              r_ou[2], r_ou[1], r_ou[0]};

endmodule

@@ hdl/lob_scale.sv @@
// ============================================================================
// lob_scale
// Block scaling of a signed 3-vector: sign and magnitude, shared shift so the
// largest magnitude lies in [2^29, 2^30). Four register stages.
// ============================================================================
module lob_scale #(
    parameter int W   = 33,
    parameter int SBW = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [W-1:0]     i_c [3],
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_vld,
    output logic                    o_nz,
    output logic [lob_pkg::MW-1:0]  o_mag [3],
    output logic [2:0]              o_neg,
    output logic [SBW-1:0]          o_sb
);
    import lob_pkg::*;

    localparam int PW = $clog2(W);

    logic [3:0]     r_v;
    logic [W-1:0]   r_mag0 [3];
    logic [W-1:0]   r_mag1 [3];
    logic [W-1:0]   r_mag2 [3];
    logic [2:0]     r_neg0, r_neg1, r_neg2, r_neg3;
    logic [SBW-1:0] r_sb0, r_sb1, r_sb2, r_sb3;
    logic [W-1:0]   r_max;
    logic [PW-1:0]  r_pos;
    logic           r_nz2, r_nz3;
    logic [MW-1:0]  r_mag3 [3];

    logic [W-1:0]   n_max;
    logic [PW-1:0]  n_pos;
    logic [MW-1:0]  n_mag [3];

    always_comb begin
        n_max = r_mag0[0];
        if (r_mag0[1] > n_max) begin
            n_max = r_mag0[1];
        end
        if (r_mag0[2] > n_max) begin
            n_max = r_mag0[2];
        end
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < W; b++) begin
            if (r_max[b]) begin
                n_pos = PW'(b);
            end
        end
    end

    always_comb begin
        logic [W+MW-1:0] ext;
        for (int l = 0; l < 3; l++) begin
            ext = (W+MW)'(r_mag2[l]);
            if (int'(r_pos) >= MW - 1) begin
                ext = ext >> (int'(r_pos) - (MW - 1));
            end else begin
                ext = ext << ((MW - 1) - int'(r_pos));
            end
            n_mag[l] = ext[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_neg0[l] <= i_c[l][W-1];
                r_mag0[l] <= i_c[l][W-1] ? W'(-i_c[l]) : W'(i_c[l]);
                r_mag1[l] <= r_mag0[l];
                r_mag2[l] <= r_mag1[l];
                r_mag3[l] <= n_mag[l];
            end
            r_sb0  <= i_sb;
            r_sb1  <= r_sb0;
            r_sb2  <= r_sb1;
            r_sb3  <= r_sb2;
            r_neg1 <= r_neg0;
            r_neg2 <= r_neg1;
            r_neg3 <= r_neg2;
            r_max  <= n_max;
            r_pos  <= n_pos;
            r_nz2  <= (r_max != '0);
            r_nz3  <= r_nz2;
        end
    end

    assign o_vld = r_v[3];
    assign o_nz  = r_nz3;
    assign o_mag = r_mag3;
    assign o_neg = r_neg3;
    assign o_sb  = r_sb3;

endmodule

@@ hdl/lob_norm.sv @@
// ============================================================================
// lob_norm
// Pipelined vector normalization: block scale, sum of squares, one root bit
// per stage, then one quotient bit per stage in three lanes.
// ============================================================================
module lob_norm #(
    parameter int W   = 33,
    parameter int SBW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic signed [W-1:0]         i_c [3],
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_vld,
    output logic                        o_nz,
    output logic signed [lob_pkg::UW-1:0] o_u [3],
    output logic [SBW-1:0]              o_sb
);
    import lob_pkg::*;

    localparam int CVW = SBW + 4 + 3 * MW;
    localparam int NST = 3 + RW + QW;

    logic           s_vld, s_nz;
    logic [MW-1:0]  s_mag [3];
    logic [2:0]     s_neg;
    logic [SBW-1:0] s_sb;

    lob_scale #(.W(W), .SBW(SBW)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (i_vld),
        .i_c     (i_c),
        .i_sb    (i_sb),
        .o_vld   (s_vld),
        .o_nz    (s_nz),
        .o_mag   (s_mag),
        .o_neg   (s_neg),
        .o_sb    (s_sb)
    );

    logic [NST-1:0]     r_v;
    logic [CVW-1:0]     r_cv  [NST];
    logic [2*MW-1:0]    r_sq  [3];
    logic [SW-1:0]      r_sum;
    logic [SW-1:0]      r_sx  [RW];
    logic [SW:0]        r_sr  [RW];
    logic [SW-1:0]      n_sx  [RW];
    logic [SW:0]        n_sr  [RW];
    logic [RW-1:0]      r_dv  [QW+1];
    logic [NW-1:0]      r_rem [QW+1][3];
    logic [QW-1:0]      r_q   [QW+1][3];
    logic [NW-1:0]      n_rem [QW][3];
    logic [QW-1:0]      n_q   [QW][3];
    logic               r_ov, r_onz;
    logic signed [UW-1:0] r_ou [3];
    logic [SBW-1:0]     r_osb;
    logic [RW-1:0]      len;

    always_comb begin
        logic [SW-1:0] x_in;
        logic [SW:0]   r_in;
        logic [SW:0]   bit_v;
        logic [SW:0]   trial;
        for (int j = 0; j < RW; j++) begin
            x_in  = (j == 0) ? r_sum : r_sx[(j == 0) ? 0 : j - 1];
            r_in  = (j == 0) ? '0 : r_sr[(j == 0) ? 0 : j - 1];
            bit_v = (SW+1)'(1) << (2 * (RW - 1 - j));
            trial = r_in + bit_v;
            if ((SW+1)'(x_in) >= trial) begin
                n_sx[j] = x_in - trial[SW-1:0];
                n_sr[j] = (r_in >> 1) + bit_v;
            end else begin
                n_sx[j] = x_in;
                n_sr[j] = r_in >> 1;
            end
        end
    end

    assign len = r_sr[RW-1][RW-1:0];

    always_comb begin
        logic [NW-1:0] dsh;
        for (int i = 0; i < QW; i++) begin
            dsh = NW'(r_dv[i]) << (QW - 1 - i);
            for (int l = 0; l < 3; l++) begin
                if (r_rem[i][l] >= dsh) begin
                    n_rem[i][l] = r_rem[i][l] - dsh;
                    n_q[i][l]   = r_q[i][l] | (QW'(1) << (QW - 1 - i));
                end else begin
                    n_rem[i][l] = r_rem[i][l];
                    n_q[i][l]   = r_q[i][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NST-2:0], s_vld};
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cv[0] <= {s_sb, s_nz, s_neg, s_mag[2], s_mag[1], s_mag[0]};
            for (int s = 1; s < NST; s++) begin
                r_cv[s] <= r_cv[s-1];
            end
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= s_mag[l] * s_mag[l];
            end
            r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            for (int j = 0; j < RW; j++) begin
                r_sx[j] <= n_sx[j];
                r_sr[j] <= n_sr[j];
            end
            r_dv[0] <= len;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= {2'b00, r_cv[1+RW][l*MW +: MW], FB'(0)}
                             + NW'(len >> 1);
                r_q[0][l]   <= '0;
            end
            for (int i = 0; i < QW; i++) begin
                r_dv[i+1] <= r_dv[i];
                for (int l = 0; l < 3; l++) begin
                    r_rem[i+1][l] <= n_rem[i][l];
                    r_q[i+1][l]   <= n_q[i][l];
                end
            end
            for (int l = 0; l < 3; l++) begin
                r_ou[l] <= r_cv[NST-1][3*MW+l]
                         ? -signed'(UW'(r_q[QW][l])) : signed'(UW'(r_q[QW][l]));
            end
            r_onz <= r_cv[NST-1][3*MW+3];
            r_osb <= r_cv[NST-1][3*MW+4 +: SBW];
        end
    end

    assign o_vld = r_ov;
    assign o_nz  = r_onz;
    assign o_u   = r_ou;
    assign o_sb  = r_osb;

endmodule

@@ hdl/lob_checker.sv @@
// ============================================================================
// lob_checker
// Port-level checks of the look-at camera basis output stream.
// ============================================================================
module lob_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [lob_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                      o_m_axis_tuser
);
    import lob_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("degenerate basis not zero");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            $signed(o_m_axis_tdata[17:0]) <= 18'sd65536 &&
            $signed(o_m_axis_tdata[17:0]) >= -18'sd65536 &&
            $signed(o_m_axis_tdata[161:144]) <= 18'sd65536 &&
            $signed(o_m_axis_tdata[161:144]) >= -18'sd65536)
        else $error("basis component out of unit range");

endmodule

bind lookat_orthonormal_basis_top lob_checker u_lob_checker (.*);

@@ tb/sv/tb_top.sv @@
// ============================================================================
// tb_top
// Checks the look-at camera basis block: random and directed view setups are
// streamed in, each basis is predicted in fixed point and compared on output.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lob_pkg::*;

    localparam int CW       = 32;
    localparam int IN_W     = ((9 * CW + 7) / 8) * 8;
    localparam int LATENCY  = 122;
    localparam int LIMIT    = 400000;

    typedef struct packed {
        logic signed [UW-1:0] rx, ry, rz, ux, uy, uz, bx, by, bz;
        logic                 degen;
    } t_basis;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_W-1:0]        i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;

    logic [IN_W-1:0] setup_q[$];
    t_basis          basis_q[$];
    int              errors;
    int              n_sent;
    int              n_checked;
    int              n_degen;
    int              cycles;
    int              send_idle;
    int              recv_idle;
    int              hold_cycles;

    lookat_orthonormal_basis_top #(.COORD_WIDTH(CW)) i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic bit scale_vec(input longint c[3], output longint unsigned mag[3],
                                     output bit neg[3]);
        longint unsigned m;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            mag[i] = neg[i] ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        return 1;
    endfunction

    function automatic bit normalize(input longint c[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        bit              neg[3];
        if (!scale_vec(c, mag, neg)) return 0;
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 65536 + len / 2) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint round_clamp(input longint x);
        longint r;
        longint unsigned m;
        m = (x < 0) ? -x : x;
        r = longint'((m + 32768) >> 16);
        if (r > 65536) r = 65536;
        return (x < 0) ? -r : r;
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_basis camera_basis(input logic [IN_W-1:0] s);
        longint          eye[3], tgt[3], upv[3], d[3], w[3], u[3], v[3], upa[3], t[3];
        longint unsigned umag[3];
        bit              uneg[3];
        bit              degen;
        t_basis          b;
        degen = 0;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(s[32*i +: 32]));
            tgt[i] = longint'($signed(s[32*(3+i) +: 32]));
            upv[i] = longint'($signed(s[32*(6+i) +: 32]));
            d[i] = eye[i] - tgt[i];
            u[i] = 0; v[i] = 0; w[i] = 0;
        end
        if (d[0] == 0 && d[2] == 0 && d[1] > 0) begin
            u[2] = 65536; v[0] = 65536; w[1] = 65536;
        end else if (d[0] == 0 && d[2] == 0 && d[1] < 0) begin
            u[0] = 65536; v[2] = 65536; w[1] = -65536;
        end else if (!normalize(d, w) || !scale_vec(upv, umag, uneg)) begin
            degen = 1;
        end else begin
            for (int i = 0; i < 3; i++) upa[i] = uneg[i] ? -longint'(umag[i]) : longint'(umag[i]);
            cross_prod(upa, w, t);
            if (!normalize(t, u)) begin
                degen = 1;
            end else begin
                cross_prod(w, u, t);
                for (int i = 0; i < 3; i++) v[i] = round_clamp(t[i]);
            end
        end
        if (degen) begin
            for (int i = 0; i < 3; i++) begin
                u[i] = 0; v[i] = 0; w[i] = 0;
            end
        end
        b.rx = UW'(u[0]); b.ry = UW'(u[1]); b.rz = UW'(u[2]);
        b.ux = UW'(v[0]); b.uy = UW'(v[1]); b.uz = UW'(v[2]);
        b.bx = UW'(w[0]); b.by = UW'(w[1]); b.bz = UW'(w[2]);
        b.degen = degen;
        return b;
    endfunction

    function automatic logic [IN_W-1:0] pack_setup(input logic [31:0] c[9]);
        logic [IN_W-1:0] s;
        s = '0;
        for (int i = 0; i < 9; i++) s[32*i +: 32] = c[i];
        return s;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rnd_setup();
        logic [31:0] c[9];
        int          k;
        for (int i = 0; i < 9; i++) c[i] = rnd_coord();
        k = $urandom_range(0, 19);
        if (k == 0) begin
            c[3] = c[0]; c[5] = c[2];
        end else if (k == 1) begin
            c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
        end else if (k == 2) begin
            c[6] = 0; c[7] = 0; c[8] = 0;
        end else if (k == 3) begin
            c[6] = 32'(c[0] - c[3]); c[7] = 32'(c[1] - c[4]); c[8] = 32'(c[2] - c[5]);
        end else if (k == 4) begin
            c[3] = c[0];
        end
        return pack_setup(c);
    endfunction

    function automatic void add_directed(input logic [31:0] c[9]);
        setup_q.push_back(pack_setup(c));
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (setup_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= setup_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            basis_q.push_back(camera_basis(i_s_axis_tdata));
            n_sent <= n_sent + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles     <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    always @(posedge i_clk) begin
        t_basis got;
        t_basis want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.rx = o_m_axis_tdata[0*UW +: UW];
            got.ry = o_m_axis_tdata[1*UW +: UW];
            got.rz = o_m_axis_tdata[2*UW +: UW];
            got.ux = o_m_axis_tdata[3*UW +: UW];
            got.uy = o_m_axis_tdata[4*UW +: UW];
            got.uz = o_m_axis_tdata[5*UW +: UW];
            got.bx = o_m_axis_tdata[6*UW +: UW];
            got.by = o_m_axis_tdata[7*UW +: UW];
            got.bz = o_m_axis_tdata[8*UW +: UW];
            got.degen = o_m_axis_tuser[0];
            n_checked <= n_checked + 1;
            if (got.degen) n_degen <= n_degen + 1;
            if (basis_q.size() == 0) begin
                $display("%0t: unexpected basis transfer, actual %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = basis_q.pop_front();
                if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                    got.ux !== want.ux || got.uy !== want.uy || got.uz !== want.uz ||
                    got.bx !== want.bx || got.by !== want.by || got.bz !== want.bz ||
                    got.degen !== want.degen) begin
                    $display("%0t: basis mismatch, expected u=(%0d %0d %0d) v=(%0d %0d %0d) w=(%0d %0d %0d) d=%0b",
                             $time, want.rx, want.ry, want.rz, want.ux, want.uy, want.uz,
                             want.bx, want.by, want.bz, want.degen);
                    $display("%0t:                 actual u=(%0d %0d %0d) v=(%0d %0d %0d) w=(%0d %0d %0d) d=%0b",
                             $time, got.rx, got.ry, got.rz, got.ux, got.uy, got.uz,
                             got.bx, got.by, got.bz, got.degen);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] c[9];
        errors = 0; n_sent = 0; n_checked = 0; n_degen = 0; cycles = 0;
        send_idle = 16; recv_idle = 60; hold_cycles = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;

        // looking down, looking up, eye at target, zero up, up along w
        c = '{0, 32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0};
        add_directed(c);
        c = '{0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0};
        add_directed(c);
        c = '{5, 6, 7, 5, 6, 7, 0, 32'h0001_0000, 0};
        add_directed(c);
        c = '{32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0};
        add_directed(c);
        c = '{0, 0, 32'h0002_0000, 0, 0, 0, 0, 0, 32'h8000_0000};
        add_directed(c);
        c = '{0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0};
        add_directed(c);
        c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        add_directed(c);
        c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1};
        add_directed(c);
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, 0};
        add_directed(c);
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1, 0};
        add_directed(c);
        c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
        add_directed(c);
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hFFFF_FFFF};
        add_directed(c);
        for (int i = 0; i < 280; i++) setup_q.push_back(rnd_setup());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (setup_q.size() != 0) @(posedge i_clk);
        send_idle = 60; recv_idle = 16;
        for (int i = 0; i < 280; i++) setup_q.push_back(rnd_setup());
        while (n_sent <= 400) @(posedge i_clk);
        hold_cycles = 400;
        while (setup_q.size() != 0) @(posedge i_clk);
        send_idle = 0; recv_idle = 0;
        for (int i = 0; i < 280; i++) setup_q.push_back(rnd_setup());
        while (setup_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (i_s_axis_tvalid) @(posedge i_clk);
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("tb_top: %0d view setups checked, %0d degenerate, across idle and stall mixes",
                 n_checked, n_degen);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
